>>> rtl/pld_pkg.sv
// shared types and constants of the pwm led shift driver
// no dependencies

package pld_pkg;

  localparam int unsigned LED_COUNT = 8;
  localparam int unsigned PWM_BITS  = 12;

  // widths of the level fields and of the widest stored word
  localparam int unsigned LEVEL_W   = 12;
  localparam int unsigned EXT_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_WRITE_RAW   = 3'd1,
    OP_WRITE_COLOR = 3'd2,
    OP_START       = 3'd3,
    OP_CLEAR_START = 3'd4
  } pld_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED_MAX   = 2'd0,
    CFG_GREEN_MAX = 2'd1,
    CFG_BLUE_MAX  = 2'd2
  } pld_cfg_e;

  typedef struct packed {
    logic clk;
    logic dat;
    logic lat;
  } pld_pins_t;

  typedef struct packed {
    logic write;
    logic clear;
  } pld_store_cmd_t;

  typedef struct packed {
    logic start;
    logic advance;
  } pld_seq_ctrl_t;

  // zero-extend a level so any word width up to EXT_W can take its low bits
  function automatic logic [EXT_W-1:0] ext_level(logic [LEVEL_W-1:0] v);
    return {{(EXT_W - LEVEL_W){1'b0}}, v};
  endfunction

endpackage

>>> rtl/pld_store.sv
// pwm word store: three words per led, one write port, clear-all, one read port
// depends on pld_pkg

module pld_store import pld_pkg::*; #(
  parameter int unsigned LedCount = LED_COUNT,
  parameter int unsigned PwmBits  = PWM_BITS,
  localparam int unsigned Channels = 3 * LedCount,
  localparam int unsigned ChW      = $clog2(Channels)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pld_store_cmd_t     cmd_i,
  input  logic [2:0]         led_i,
  input  logic [PwmBits-1:0] red_i,
  input  logic [PwmBits-1:0] green_i,
  input  logic [PwmBits-1:0] blue_i,
  input  logic [ChW-1:0]     rd_addr_i,
  output logic [PwmBits-1:0] rd_word_o
);

  logic [PwmBits-1:0] word_q [Channels];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned c = 0; c < Channels; c++) begin
        word_q[c] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int unsigned c = 0; c < Channels; c++) begin
        word_q[c] <= '0;
      end
    end else if (cmd_i.write) begin
      for (int unsigned l = 0; l < LedCount; l++) begin
        if (32'(led_i) == l) begin
          word_q[3*l]     <= red_i;
          word_q[3*l + 1] <= green_i;
          word_q[3*l + 2] <= blue_i;
        end
      end
    end
  end

  assign rd_word_o = word_q[rd_addr_i];

endmodule

>>> rtl/pld_seq.sv
// update sequencer: walks channels and bits, drives clock, data and latch pins
// depends on pld_pkg

module pld_seq import pld_pkg::*; #(
  parameter int unsigned LedCount = LED_COUNT,
  parameter int unsigned PwmBits  = PWM_BITS,
  localparam int unsigned Channels = 3 * LedCount,
  localparam int unsigned ChW      = $clog2(Channels),
  localparam int unsigned BitW     = $clog2(PwmBits)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pld_seq_ctrl_t      ctrl_i,
  input  logic [PwmBits-1:0] rd_word_i,
  output logic [ChW-1:0]     rd_addr_o,
  output logic               busy_o,
  output pld_pins_t          pins_d_o,
  output logic               busy_d_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SHIFT,
    PH_LATCH_HIGH,
    PH_LATCH_LOW
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [ChW-1:0]  chan_q, chan_d;
  logic [BitW-1:0] bit_q, bit_d;
  logic            half_q, half_d;
  pld_pins_t       pins_q, pins_d;

  always_comb begin
    phase_d = phase_q;
    chan_d  = chan_q;
    bit_d   = bit_q;
    half_d  = half_q;
    pins_d  = pins_q;
    if (ctrl_i.start) begin
      pins_d.lat = 1'b0;
      chan_d     = ChW'(Channels - 1);
      bit_d      = BitW'(PwmBits - 1);
      half_d     = 1'b0;
      phase_d    = PH_SHIFT;
    end else if (ctrl_i.advance) begin
      case (phase_q)
        PH_SHIFT: begin
          if (!half_q) begin
            pins_d.clk = 1'b0;
            pins_d.dat = rd_word_i[bit_q];
            half_d     = 1'b1;
          end else begin
            pins_d.clk = 1'b1;
            half_d     = 1'b0;
            if (bit_q != '0) begin
              bit_d = bit_q - 1'b1;
            end else if (chan_q != '0) begin
              chan_d = chan_q - 1'b1;
              bit_d  = BitW'(PwmBits - 1);
            end else begin
              phase_d = PH_LATCH_HIGH;
            end
          end
        end
        PH_LATCH_HIGH: begin
          pins_d.clk = 1'b0;
          pins_d.lat = 1'b1;
          phase_d    = PH_LATCH_LOW;
        end
        PH_LATCH_LOW: begin
          pins_d.lat = 1'b0;
          phase_d    = PH_IDLE;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      chan_q  <= '0;
      bit_q   <= '0;
      half_q  <= 1'b0;
      pins_q  <= '0;
    end else begin
      phase_q <= phase_d;
      chan_q  <= chan_d;
      bit_q   <= bit_d;
      half_q  <= half_d;
      pins_q  <= pins_d;
    end
  end

  assign rd_addr_o = chan_q;
  assign busy_o    = (phase_q != PH_IDLE);
  assign pins_d_o  = pins_d;
  assign busy_d_o  = (phase_d != PH_IDLE);

endmodule

>>> rtl/pwm_led_shift_driver_unit.sv
// Serial front end for a chain of 24-channel 12-bit PWM LED drivers.
//
// Input channel (in_valid_i / in_ready_o): one transaction per tick. The
// operation writes raw levels for one LED, writes a colour code through the
// max-level registers, starts an update or clears every word and starts one.
// While an update runs every transaction advances the pin waveform by one
// step, half a bit while shifting; writes or starts are flagged rejected.
// Output channel (out_valid_o / out_ready_i): exactly one result per input
// transaction, carrying the pin levels after that tick, busy and rejected.
// Config channel (cfg_valid_i / cfg_ready_o): max-level registers, always
// ready, written by the user only while idle; the block does not enforce it.
// Results are registered, valid the cycle after accept. Throughput is one
// transaction per cycle, set by the single output register: input is taken
// whenever that register is empty or being drained in the same cycle, so a
// stalled receiver holds the input off once one result is waiting.
// Reset clears all PWM words, the sequencer and its pin state, and sets the
// max-level registers to full scale; the result data register is not reset.
// depends on pld_pkg, pld_store, pld_seq

module pwm_led_shift_driver_unit import pld_pkg::*; #(
  parameter int unsigned LedCount = LED_COUNT,
  parameter int unsigned PwmBits  = PWM_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           operation_i,
  input  logic [2:0]           led_index_i,
  input  logic [LEVEL_W-1:0]   red_level_i,
  input  logic [LEVEL_W-1:0]   green_level_i,
  input  logic [LEVEL_W-1:0]   blue_level_i,
  input  logic [2:0]           color_code_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 serial_clock_o,
  output logic                 serial_data_o,
  output logic                 latch_pin_o,
  output logic                 busy_res_o,
  output logic                 rejected_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEVEL_W-1:0]   cfg_data_i
);

  localparam int unsigned Channels = 3 * LedCount;
  localparam int unsigned ChW      = $clog2(Channels);

  logic [LEVEL_W-1:0] red_max_q, green_max_q, blue_max_q;

  logic               accept;
  logic               busy;
  logic               led_ok;
  pld_store_cmd_t     store_cmd;
  pld_seq_ctrl_t      seq_ctrl;
  logic               reject;
  logic [EXT_W-1:0]   red_ext, green_ext, blue_ext;
  logic [LEVEL_W-1:0] red_sel, green_sel, blue_sel;
  logic [ChW-1:0]     rd_addr;
  logic [PwmBits-1:0] rd_word;
  pld_pins_t          pins_d;
  logic               busy_d;

  logic               out_valid_q;
  pld_pins_t          pins_out_q;
  logic               busy_out_q;
  logic               rej_out_q;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_max_q   <= LEVEL_MAX;
      green_max_q <= LEVEL_MAX;
      blue_max_q  <= LEVEL_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (pld_cfg_e'(cfg_index_i))
        CFG_RED_MAX:   red_max_q   <= cfg_data_i;
        CFG_GREEN_MAX: green_max_q <= cfg_data_i;
        CFG_BLUE_MAX:  blue_max_q  <= cfg_data_i;
        default:       red_max_q   <= red_max_q;
      endcase
    end
  end

  // operation decode
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign led_ok     = (32'(led_index_i) < LedCount);

  always_comb begin
    store_cmd = '0;
    seq_ctrl  = '0;
    reject    = 1'b0;
    red_sel   = red_level_i;
    green_sel = green_level_i;
    blue_sel  = blue_level_i;
    if (accept) begin
      if (busy) begin
        seq_ctrl.advance = 1'b1;
        case (pld_op_e'(operation_i))
          OP_WRITE_RAW, OP_WRITE_COLOR, OP_START, OP_CLEAR_START: reject = 1'b1;
          default: reject = 1'b0;
        endcase
      end else begin
        case (pld_op_e'(operation_i))
          OP_WRITE_RAW: begin
            store_cmd.write = led_ok;
          end
          OP_WRITE_COLOR: begin
            store_cmd.write = led_ok;
            red_sel   = color_code_i[0] ? red_max_q   : '0;
            green_sel = color_code_i[1] ? green_max_q : '0;
            blue_sel  = color_code_i[2] ? blue_max_q  : '0;
          end
          OP_START: begin
            seq_ctrl.start = 1'b1;
          end
          OP_CLEAR_START: begin
            store_cmd.clear = 1'b1;
            seq_ctrl.start  = 1'b1;
          end
          default: begin
            seq_ctrl = '0;
          end
        endcase
      end
    end
  end

  assign red_ext   = ext_level(red_sel);
  assign green_ext = ext_level(green_sel);
  assign blue_ext  = ext_level(blue_sel);

  pld_store #(
    .LedCount (LedCount),
    .PwmBits  (PwmBits)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (store_cmd),
    .led_i     (led_index_i),
    .red_i     (red_ext[PwmBits-1:0]),
    .green_i   (green_ext[PwmBits-1:0]),
    .blue_i    (blue_ext[PwmBits-1:0]),
    .rd_addr_i (rd_addr),
    .rd_word_o (rd_word)
  );

  pld_seq #(
    .LedCount (LedCount),
    .PwmBits  (PwmBits)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (seq_ctrl),
    .rd_word_i (rd_word),
    .rd_addr_o (rd_addr),
    .busy_o    (busy),
    .pins_d_o  (pins_d),
    .busy_d_o  (busy_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pins_out_q <= pins_d;
      busy_out_q <= busy_d;
      rej_out_q  <= reject;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign serial_clock_o = pins_out_q.clk;
  assign serial_data_o  = pins_out_q.dat;
  assign latch_pin_o    = pins_out_q.lat;
  assign busy_res_o     = busy_out_q;
  assign rejected_o     = rej_out_q;

endmodule

>>> test/pwm_led_shift_driver_unit_test.sv
// self-checking testbench for pwm_led_shift_driver_unit: directed and random
// led writes, colour writes and update sequences checked tick by tick
// depends on pld_pkg and the pwm_led_shift_driver_unit rtl
`timescale 1ns / 1ps

module pwm_led_shift_driver_unit_test;
  import pld_pkg::*;

  localparam int CHANNELS       = 3 * LED_COUNT;
  // ticks after the start transaction until busy drops
  localparam int SEQ_STEPS      = CHANNELS * PWM_BITS * 2 + 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_TARGET  = 1830;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SHIFT,
    SEQ_LATCH_HI,
    SEQ_LATCH_LO
  } seq_phase_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [2:0]         led;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [2:0]         code;
  } led_cmd_t;

  typedef struct packed {
    logic sclk;
    logic sdat;
    logic latch;
    logic busy;
    logic rej;
  } pin_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  led_cmd_t             in_cmd = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RED_MAX;
  logic [LEVEL_W-1:0]   cfg_data = '0;
  logic                 in_ready, out_valid, cfg_ready;
  logic                 sclk_pin, sdat_pin, latch_pin, busy_flag, rej_flag;

  pwm_led_shift_driver_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (in_cmd.op),
    .led_index_i    (in_cmd.led),
    .red_level_i    (in_cmd.red),
    .green_level_i  (in_cmd.green),
    .blue_level_i   (in_cmd.blue),
    .color_code_i   (in_cmd.code),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .serial_clock_o (sclk_pin),
    .serial_data_o  (sdat_pin),
    .latch_pin_o    (latch_pin),
    .busy_res_o     (busy_flag),
    .rejected_o     (rej_flag),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the block state
  logic [PWM_BITS-1:0] shadow_words [CHANNELS];
  logic [LEVEL_W-1:0]  max_level [3];
  seq_phase_e          shadow_phase = SEQ_IDLE;
  logic [4:0]          shadow_chan = '0;
  logic [3:0]          shadow_bit = '0;
  logic                shadow_half = 1'b0;
  pld_pins_t           shadow_pins = '0;

  led_cmd_t    queued_cmds [$];
  pin_result_t expected_pins [$];
  int          issued_cmds = 0;
  int          accepted_cmds = 0;
  int          busy_left = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          stall_cycles = 0;
  logic        in_taken = 1'b0;

  // advance the shadow state by one transaction and return the pin levels
  task automatic predict_pin_step(input led_cmd_t cmd, output pin_result_t res);
    int   base;
    logic reject;
    logic [PWM_BITS-1:0] word;
    base   = 3 * int'(cmd.led);
    reject = 1'b0;
    if (shadow_phase != SEQ_IDLE) begin
      reject = (cmd.op == OP_WRITE_RAW) || (cmd.op == OP_WRITE_COLOR) ||
               (cmd.op == OP_START) || (cmd.op == OP_CLEAR_START);
      case (shadow_phase)
        SEQ_SHIFT: begin
          if (!shadow_half) begin
            word            = shadow_words[shadow_chan];
            shadow_pins.clk = 1'b0;
            shadow_pins.dat = word[shadow_bit];
            shadow_half     = 1'b1;
          end else begin
            shadow_pins.clk = 1'b1;
            shadow_half     = 1'b0;
            if (shadow_bit != 0) begin
              shadow_bit--;
            end else if (shadow_chan != 0) begin
              shadow_chan--;
              shadow_bit = 4'(PWM_BITS - 1);
            end else begin
              shadow_phase = SEQ_LATCH_HI;
            end
          end
        end
        SEQ_LATCH_HI: begin
          shadow_pins.clk = 1'b0;
          shadow_pins.lat = 1'b1;
          shadow_phase    = SEQ_LATCH_LO;
        end
        default: begin
          shadow_pins.lat = 1'b0;
          shadow_phase    = SEQ_IDLE;
        end
      endcase
    end else if (cmd.op == OP_WRITE_RAW && cmd.led < LED_COUNT) begin
      shadow_words[base]     = cmd.red[PWM_BITS-1:0];
      shadow_words[base + 1] = cmd.green[PWM_BITS-1:0];
      shadow_words[base + 2] = cmd.blue[PWM_BITS-1:0];
    end else if (cmd.op == OP_WRITE_COLOR && cmd.led < LED_COUNT) begin
      shadow_words[base]     = cmd.code[0] ? max_level[CFG_RED_MAX] : '0;
      shadow_words[base + 1] = cmd.code[1] ? max_level[CFG_GREEN_MAX] : '0;
      shadow_words[base + 2] = cmd.code[2] ? max_level[CFG_BLUE_MAX] : '0;
    end else if (cmd.op == OP_START || cmd.op == OP_CLEAR_START) begin
      if (cmd.op == OP_CLEAR_START) begin
        foreach (shadow_words[i]) shadow_words[i] = '0;
      end
      shadow_pins.lat = 1'b0;
      shadow_chan     = 5'(CHANNELS - 1);
      shadow_bit      = 4'(PWM_BITS - 1);
      shadow_half     = 1'b0;
      shadow_phase    = SEQ_SHIFT;
    end
    res.sclk  = shadow_pins.clk;
    res.sdat  = shadow_pins.dat;
    res.latch = shadow_pins.lat;
    res.busy  = (shadow_phase != SEQ_IDLE);
    res.rej   = reject;
  endtask

  task automatic check_bit(input string what, input logic want, input logic got);
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("%0t: %s mismatch on result %0d, expected %b, got %b",
                 $time, what, results_seen, want, got);
      end
      mismatches++;
    end
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return LEVEL_MAX;
    return LEVEL_W'($urandom_range(0, 4095));
  endfunction

  function automatic led_cmd_t rand_cmd(input logic [2:0] op);
    led_cmd_t cmd;
    cmd.op    = op;
    cmd.led   = 3'($urandom_range(0, 7));
    cmd.red   = pick_level();
    cmd.green = pick_level();
    cmd.blue  = pick_level();
    cmd.code  = 3'($urandom_range(0, 7));
    return cmd;
  endfunction

  // queue a transaction and track whether it lands inside an update
  function automatic void push_cmd(input led_cmd_t cmd);
    if (busy_left != 0) begin
      busy_left--;
    end else if (cmd.op == OP_START || cmd.op == OP_CLEAR_START) begin
      busy_left = SEQ_STEPS;
    end
    queued_cmds.push_back(cmd);
    issued_cmds++;
  endfunction

  // run any update to its end and wait until every result is back
  task automatic finish_phase();
    while (busy_left != 0) push_cmd(rand_cmd(OP_TICK));
    while (accepted_cmds != issued_cmds || expected_pins.size() != 0) @(negedge clk);
  endtask

  task automatic write_max_level(input pld_cfg_e idx, input logic [LEVEL_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    max_level[int'(idx)] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_max_levels(input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] g,
                                input logic [LEVEL_W-1:0] b);
    write_max_level(CFG_RED_MAX, r);
    write_max_level(CFG_GREEN_MAX, g);
    write_max_level(CFG_BLUE_MAX, b);
  endtask

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (rst_n && gap_left == 0 && queued_cmds.size() != 0) begin
        in_cmd   <= queued_cmds.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  // receiver: stall pattern changes every so often, one long hold-off
  int   rx_mode = 0;
  int   mode_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && accepted_cmds >= 400) begin
      hold_done = 1'b1;
      hold_left = 160;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor: predict on input transactions, check output transactions
  pin_result_t want_res, got_res;

  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      predict_pin_step(in_cmd, want_res);
      expected_pins.push_back(want_res);
      accepted_cmds++;
    end
    if (rst_n && out_valid && out_ready) begin
      got_res = '{sclk_pin, sdat_pin, latch_pin, busy_flag, rej_flag};
      if (expected_pins.size() == 0) begin
        if (mismatches < 10) $display("%0t: result with no transaction pending", $time);
        mismatches++;
      end else begin
        want_res = expected_pins.pop_front();
        check_bit("serial_clock", want_res.sclk, got_res.sclk);
        check_bit("serial_data", want_res.sdat, got_res.sdat);
        check_bit("latch_pin", want_res.latch, got_res.latch);
        check_bit("busy", want_res.busy, got_res.busy);
        check_bit("rejected", want_res.rej, got_res.rej);
      end
      results_seen++;
    end
  end

  initial begin
    @(posedge rst_n);
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("** pwm_led_shift_driver_unit: FAILED **");
    $finish;
  end

  initial begin
    int       blk;
    int       sel;
    led_cmd_t cmd;
    foreach (shadow_words[i]) shadow_words[i] = '0;
    foreach (max_level[i]) max_level[i] = LEVEL_MAX;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: undefined codes, colour codes through odd max levels,
    // extreme raw levels, then every operation while busy
    set_max_levels(LEVEL_MAX, 12'h800, 12'h001);
    push_cmd(rand_cmd(3'd5));
    push_cmd(rand_cmd(3'd6));
    push_cmd(rand_cmd(3'd7));
    for (int k = 0; k < 8; k++) begin
      cmd      = rand_cmd(OP_WRITE_COLOR);
      cmd.led  = 3'(k);
      cmd.code = 3'(k);
      push_cmd(cmd);
    end
    push_cmd('{OP_WRITE_RAW, 3'd0, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, 3'd7});
    push_cmd('{OP_WRITE_RAW, 3'd7, 12'h000, 12'h000, 12'h000, 3'd0});
    push_cmd('{OP_WRITE_RAW, 3'd3, 12'ha5a, 12'h5a5, 12'h801, 3'd2});
    push_cmd(rand_cmd(OP_START));
    for (int k = 0; k < 8; k++) push_cmd(rand_cmd(3'(k)));
    finish_phase();
    // clear and update, so the cleared words go out on this same update
    push_cmd(rand_cmd(OP_CLEAR_START));
    finish_phase();

    blk = 0;
    // stop before one more full update would overshoot the item budget
    while (issued_cmds + SEQ_STEPS < RANDOM_TARGET) begin
      case (blk % 4)
        0:       set_max_levels('0, '0, '0);
        1:       set_max_levels(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        2:       set_max_levels(pick_level(), pick_level(), pick_level());
        default: set_max_levels(LEVEL_MAX, '0, LEVEL_W'($urandom_range(0, 4095)));
      endcase
      repeat ($urandom_range(1, 14)) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) push_cmd(rand_cmd(OP_TICK));
        else if (sel == 1) push_cmd(rand_cmd(3'($urandom_range(5, 7))));
        else if (sel < 6) push_cmd(rand_cmd(OP_WRITE_RAW));
        else push_cmd(rand_cmd(OP_WRITE_COLOR));
      end
      // now and then a block with no update at all
      if ($urandom_range(0, 5) != 0) begin
        push_cmd(rand_cmd(($urandom_range(0, 3) == 0) ? OP_CLEAR_START : OP_START));
      end
      while (busy_left != 0) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) push_cmd(rand_cmd(OP_TICK));
        else if (sel < 92) push_cmd(rand_cmd(3'($urandom_range(1, 4))));
        else push_cmd(rand_cmd(3'($urandom_range(5, 7))));
      end
      finish_phase();
      blk++;
    end

    repeat (8) @(posedge clk);
    mismatches += expected_pins.size();
    if (mismatches == 0) begin
      $display("** pwm_led_shift_driver_unit: PASSED **");
    end else begin
      $display("** pwm_led_shift_driver_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pld_pkg.sv
rtl/pld_store.sv
rtl/pld_seq.sv
rtl/pwm_led_shift_driver_unit.sv
test/pwm_led_shift_driver_unit_test.sv
